// File: hdl/pwm_ramp_limiter_core_assert.svh
// ----------------------------------------------------------------------------
// pwm_ramp_limiter_core_assert.svh
// Assertion macros shared by the PWM ramp limiter checkers.
// ----------------------------------------------------------------------------
`ifndef PWM_RAMP_LIMITER_CORE_ASSERT_SVH
`define PWM_RAMP_LIMITER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define PRL_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PRL_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// Types and constants for the PWM ramp limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package prl_pkg;

	localparam int DUTY_W    = 8;
	localparam int TIME_W    = 16;
	localparam int PROD_W    = DUTY_W + TIME_W;
	localparam int CREDIT_W  = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [DUTY_W-1:0] LOW_END_RST   = 8'd0;
	localparam logic [DUTY_W-1:0] HIGH_END_RST  = 8'd255;
	localparam logic [TIME_W-1:0] RAMP_UP_RST   = 16'd10;
	localparam logic [TIME_W-1:0] RAMP_DOWN_RST = 16'd30;
	localparam logic [TIME_W-1:0] TICK_RST      = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PWM_LOW_END  = 3'd0,
		CFG_PWM_HIGH_END = 3'd1,
		CFG_RAMP_UP      = 3'd2,
		CFG_RAMP_DOWN    = 3'd3,
		CFG_TICK         = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_ACC
	} prl_state_t;

endpackage : prl_pkg

`default_nettype wire

// File: hdl/prl_serial_div.sv
// ----------------------------------------------------------------------------
// prl_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module prl_serial_div
	import prl_pkg::*;
#(
	parameter int DIVIDEND_W = 40
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [TIME_W-1:0]     divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [TIME_W-1:0]     rem_q;
	logic [TIME_W-1:0]     dvsr_q;
	logic [DIVIDEND_W-1:0] dq_q;

	logic [TIME_W:0]       shifted;
	logic [TIME_W:0]       trial;
	logic                  fits;

	// Shift the next dividend bit into the partial remainder and try the subtract.
	assign shifted = {rem_q, dq_q[DIVIDEND_W-1]};
	assign trial   = shifted - {1'b0, dvsr_q};
	assign fits    = !trial[TIME_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIVIDEND_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvsr_q <= divisor;
			dq_q   <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule : prl_serial_div

`default_nettype wire

// File: hdl/pwm_ramp_limiter_core.sv
// ----------------------------------------------------------------------------
// pwm_ramp_limiter_core
// Slew-rate limiter for a fan PWM value with fractional per-direction credit.
// ----------------------------------------------------------------------------
//  channel   | direction | payload (low bits first)         | handshake
//  s_axis    | in        | present_duty[7:0], wanted_duty   | tvalid/tready
//  m_axis    | out       | next_duty[7:0]                   | tvalid/tready
//  cfg       | in        | cfg_index (reg 0..4), cfg_data   | cfg_valid/cfg_ready
//
//  An item passes from the input register through the prep step and the
//  bit-serial divider, which produces span*tick/ramp one quotient bit per cycle,
//  to the accumulate step; equal or empty-band items skip the divider.
//  One item is in flight at a time; the next input is taken once the result sits
//  in the output register, even if the sink has not yet taken it.
//  Reset clears both credits and loads the register defaults; no clearing pass.
//  A stalled sink holds the finished item in the last step until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_ramp_limiter_core
	import prl_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [15:0]          s_axis_tdata,   // [7:0] present_duty, [15:8] wanted_duty

	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [7:0]                m_axis_tdata,   // [7:0] next_duty

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int DIVIDEND_W = PROD_W + FRACTION_BITS;
	localparam int SUM_W      = ((DIVIDEND_W > CREDIT_W) ? DIVIDEND_W : CREDIT_W) + 1;
	localparam logic [CREDIT_W-1:0] FracMask =
		CREDIT_W'((64'd1 << FRACTION_BITS) - 64'd1);

	// Configuration registers
	logic [DUTY_W-1:0] low_end_q;
	logic [DUTY_W-1:0] high_end_q;
	logic [TIME_W-1:0] ramp_up_q;
	logic [TIME_W-1:0] ramp_down_q;
	logic [TIME_W-1:0] tick_q;

	// Item state
	prl_state_t        state_q, state_d;
	logic [DUTY_W-1:0] present_q, wanted_q;
	logic [DUTY_W-1:0] cur_q, tgt_q;
	logic              up_q, stronger_q, skip_q;
	logic [CREDIT_W-1:0] credit_str_q, credit_weak_q;

	// Output register
	logic              out_valid_q;
	logic [DUTY_W-1:0] next_duty_q;

	// Control from the sequencer
	logic in_fire, prep_en, div_start, acc_fire, out_free;

	// Prep-stage logic
	logic              band_fwd;
	logic [DUTY_W-1:0] lo, hi, cur_c, tgt_c, span;
	logic              up_c, stronger_c, skip_c;
	logic [TIME_W-1:0] ramp_sel, ramp_eff, tick_eff;
	logic [PROD_W-1:0] product;

	// Divider
	logic                  div_done;
	logic [DIVIDEND_W-1:0] quotient;

	// Accumulate-stage logic
	logic [CREDIT_W-1:0] credit_sel, credit_new;
	logic [SUM_W-1:0]    credit_sum;
	logic                sat;
	logic                step_nz, step_big;
	logic [DUTY_W-1:0]   step_lo, gap, step_eff, result;

	// ------------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_end_q   <= LOW_END_RST;
			high_end_q  <= HIGH_END_RST;
			ramp_up_q   <= RAMP_UP_RST;
			ramp_down_q <= RAMP_DOWN_RST;
			tick_q      <= TICK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PWM_LOW_END:  low_end_q   <= cfg_data[DUTY_W-1:0];
				CFG_PWM_HIGH_END: high_end_q  <= cfg_data[DUTY_W-1:0];
				CFG_RAMP_UP:      ramp_up_q   <= cfg_data;
				CFG_RAMP_DOWN:    ramp_down_q <= cfg_data;
				CFG_TICK:         tick_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		prep_en       = 1'b0;
		div_start     = 1'b0;
		acc_fire      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				prep_en = 1'b1;
				if (skip_c) begin
					state_d = ST_ACC;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (out_free) begin
					acc_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			present_q <= s_axis_tdata[DUTY_W-1:0];
			wanted_q  <= s_axis_tdata[2*DUTY_W-1:DUTY_W];
		end
	end

	// ------------------------------------------------------------------------
	// Prep: clamp into the band, pick direction and divisor
	// ------------------------------------------------------------------------
	assign band_fwd = high_end_q >= low_end_q;
	assign lo       = band_fwd ? low_end_q : high_end_q;
	assign hi       = band_fwd ? high_end_q : low_end_q;
	assign cur_c    = (present_q < lo) ? lo : ((present_q > hi) ? hi : present_q);
	assign tgt_c    = (wanted_q < lo) ? lo : ((wanted_q > hi) ? hi : wanted_q);
	assign span     = hi - lo;
	assign skip_c   = (cur_c == tgt_c) || (span == '0);
	assign up_c     = tgt_c > cur_c;
	assign stronger_c = band_fwd ? up_c : !up_c;
	assign ramp_sel = stronger_c ? ramp_up_q : ramp_down_q;
	assign ramp_eff = (ramp_sel == '0) ? TIME_W'(1) : ramp_sel;
	assign tick_eff = (tick_q == '0) ? TIME_W'(1) : tick_q;
	assign product  = PROD_W'(span) * PROD_W'(tick_eff);

	always_ff @(posedge clk) begin
		if (prep_en) begin
			cur_q      <= cur_c;
			tgt_q      <= tgt_c;
			up_q       <= up_c;
			stronger_q <= stronger_c;
			skip_q     <= skip_c;
		end
	end

	prl_serial_div #(
		.DIVIDEND_W (DIVIDEND_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({product, {FRACTION_BITS{1'b0}}}),
		.divisor  (ramp_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	// ------------------------------------------------------------------------
	// Accumulate: add to the credit, take the integer step, move without overshoot
	// ------------------------------------------------------------------------
	assign credit_sel = stronger_q ? credit_str_q : credit_weak_q;
	assign credit_sum = SUM_W'(credit_sel) + SUM_W'(quotient);
	assign sat        = |(credit_sum >> CREDIT_W);
	assign credit_new = sat ? '1 : credit_sum[CREDIT_W-1:0];

	assign step_nz  = |(credit_new >> FRACTION_BITS);
	assign step_big = |(credit_new >> (FRACTION_BITS + DUTY_W));
	assign step_lo  = credit_new[FRACTION_BITS +: DUTY_W];
	assign gap      = up_q ? (tgt_q - cur_q) : (cur_q - tgt_q);
	assign step_eff = (step_big || (step_lo > gap)) ? gap : step_lo;

	always_comb begin
		result = cur_q;
		if (!skip_q && step_nz) begin
			result = up_q ? (cur_q + step_eff) : (cur_q - step_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_str_q  <= '0;
			credit_weak_q <= '0;
		end else if (acc_fire) begin
			// Drop the whole part that was spent; the fraction carries over.
			if (skip_q) begin
				credit_str_q  <= '0;
				credit_weak_q <= '0;
			end else if (stronger_q) begin
				credit_str_q  <= credit_new & FracMask;
				credit_weak_q <= '0;
			end else begin
				credit_str_q  <= '0;
				credit_weak_q <= credit_new & FracMask;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_fire) begin
			next_duty_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = next_duty_q;

endmodule : pwm_ramp_limiter_core

`default_nettype wire

// File: hdl/prl_checker.sv
// ----------------------------------------------------------------------------
// prl_checker
// Port-level checks for the PWM ramp limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_ramp_limiter_core_assert.svh"

module prl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	logic [1:0] pend_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// Count items taken in whose result has not yet been transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
		end
	end

	`PRL_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`PRL_ASSERT(a_one_in_flight, clk, arst_n, in_xfer |=> !s_axis_tready, "input taken while an item is in work")
	`PRL_ASSERT(a_no_phantom, clk, arst_n, m_axis_tvalid |-> (pend_q != 2'd0) && (pend_q != 2'd3), "result without a pending input")
	`PRL_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule : prl_checker

bind pwm_ramp_limiter_core prl_checker u_prl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the PWM ramp limiter core against a cycle-free predictor of the
// per-direction fractional credit. Ticks are streamed in with random gaps and
// sink stalls. Results are matched in order, and the registers are reprogrammed
// between phases while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

import prl_pkg::*;

class duty_scoreboard #(int FRAC = 16);

	localparam logic [63:0] CREDIT_LIMIT = (64'd1 << CREDIT_W) - 64'd1;

	logic [DUTY_W-1:0]   low_end;
	logic [DUTY_W-1:0]   high_end;
	logic [TIME_W-1:0]   ramp_up;
	logic [TIME_W-1:0]   ramp_fall;
	logic [TIME_W-1:0]   tick_len;
	logic [CREDIT_W-1:0] credit_stronger;
	logic [CREDIT_W-1:0] credit_weaker;
	logic [DUTY_W-1:0]   last_duty;
	logic [DUTY_W-1:0]   expected_duty[$];
	int unsigned         mismatches;

	function new();
		low_end         = LOW_END_RST;
		high_end        = HIGH_END_RST;
		ramp_up         = RAMP_UP_RST;
		ramp_fall       = RAMP_DOWN_RST;
		tick_len        = TICK_RST;
		credit_stronger = '0;
		credit_weaker   = '0;
		last_duty       = '0;
		mismatches      = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		case (idx)
			CFG_PWM_LOW_END:  low_end   = data[DUTY_W-1:0];
			CFG_PWM_HIGH_END: high_end  = data[DUTY_W-1:0];
			CFG_RAMP_UP:      ramp_up   = data[TIME_W-1:0];
			CFG_RAMP_DOWN:    ramp_fall = data[TIME_W-1:0];
			CFG_TICK:         tick_len  = data[TIME_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the credit state for one accepted tick and queue its next_duty.
	function void note_tick(logic [DUTY_W-1:0] present, logic [DUTY_W-1:0] wanted);
		logic [DUTY_W-1:0] lo, hi, cur, tgt, span, gap, duty;
		logic [63:0]       ramp, secs, gain, c, step;
		logic              up, stronger;
		lo   = (low_end < high_end) ? low_end : high_end;
		hi   = (low_end < high_end) ? high_end : low_end;
		cur  = (present < lo) ? lo : ((present > hi) ? hi : present);
		tgt  = (wanted < lo) ? lo : ((wanted > hi) ? hi : wanted);
		span = hi - lo;
		duty = cur;
		if (cur == tgt || span == 0) begin
			credit_stronger = '0;
			credit_weaker   = '0;
		end else begin
			up       = tgt > cur;
			// an inverted band makes the numerically lower end the stronger one
			stronger = (high_end >= low_end) ? up : !up;
			ramp     = stronger ? 64'(ramp_up) : 64'(ramp_fall);
			if (ramp == 0)
				ramp = 1;
			secs = (tick_len == 0) ? 64'd1 : 64'(tick_len);
			gain = ((64'(span) * secs) << FRAC) / ramp;
			c = stronger ? 64'(credit_stronger) : 64'(credit_weaker);
			if (gain > CREDIT_LIMIT || c > CREDIT_LIMIT - gain)
				c = CREDIT_LIMIT;
			else
				c = c + gain;
			step = c >> FRAC;
			if (step != 0) begin
				gap = up ? tgt - cur : cur - tgt;
				// the whole step leaves the credit even when the move is clipped
				c = c - (step << FRAC);
				if (step > 64'(gap))
					step = 64'(gap);
				duty = up ? cur + step[DUTY_W-1:0] : cur - step[DUTY_W-1:0];
			end
			if (stronger) begin
				credit_stronger = c[CREDIT_W-1:0];
				credit_weaker   = '0;
			end else begin
				credit_weaker   = c[CREDIT_W-1:0];
				credit_stronger = '0;
			end
		end
		last_duty = duty;
		expected_duty.push_back(duty);
	endfunction

	function void check_duty(logic [DUTY_W-1:0] got);
		logic [DUTY_W-1:0] want;
		if (expected_duty.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("next_duty %0d arrived with no tick outstanding", got);
		end else begin
			want = expected_duty.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("next_duty mismatch: expected %0d, got %0d", want, got);
			end
		end
	endfunction

	function int pending();
		return expected_duty.size();
	endfunction

	function bit failed();
		return mismatches != 0 || expected_duty.size() != 0;
	endfunction

endclass

module testbench;

	localparam int FRACTION     = 16;
	localparam int SETTLE_TICKS = FRACTION + 27 + 16;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_SINK,
		IDLE_BOTH
	} idle_mode_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 s_axis_tvalid  = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata   = '0;  // [7:0] present_duty, [15:8] wanted_duty
	logic                 m_axis_tvalid;
	logic                 m_axis_tready  = 1'b0;
	logic [7:0]           m_axis_tdata;         // [7:0] next_duty
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_DAT_W-1:0] cfg_data       = '0;

	int send_idle_pct  = 0;
	int sink_stall_pct = 0;

	duty_scoreboard #(FRACTION) sb;

	pwm_ramp_limiter_core #(.FRACTION_BITS(FRACTION)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_duty(m_axis_tdata);
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [TIME_W-1:0] pick_seconds();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return TIME_W'($urandom);
			default: return TIME_W'($urandom_range(1, 60));
		endcase
	endfunction

	task automatic set_idle(input idle_mode_t mode);
		send_idle_pct  = (mode == IDLE_SENDER) ? 86 : ((mode == IDLE_BOTH) ? 24 : 0);
		sink_stall_pct = (mode == IDLE_SINK) ? 86 : ((mode == IDLE_BOTH) ? 24 : 0);
	endtask

	// Leave valid high after the transfer; the caller or the next call drops it.
	task automatic send_tick(input logic [7:0] present, input logic [7:0] wanted);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {wanted, present};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_tick(present, wanted);
	endtask

	task automatic wait_results();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Duty ends carry random upper bits so the register masking is exercised.
	task automatic program_regs(input logic [7:0] lo, input logic [7:0] hi,
			input logic [15:0] up, input logic [15:0] dn, input logic [15:0] tk);
		write_reg(CFG_PWM_LOW_END, {8'($urandom), lo});
		write_reg(CFG_PWM_HIGH_END, {8'($urandom), hi});
		write_reg(CFG_RAMP_UP, up);
		write_reg(CFG_RAMP_DOWN, dn);
		write_reg(CFG_TICK, tk);
		write_reg(CFG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		wait_results();
	endtask

	// Mostly closed-loop runs that feed back the last output toward a held
	// target, so credit builds over many ticks; the rest is unrelated noise.
	task automatic run_random_phase(input int count);
		int         sent;
		int         run_left;
		logic [7:0] goal;
		logic [7:0] present;
		logic [7:0] wanted;
		sent     = 0;
		run_left = 0;
		goal     = 8'($urandom);
		while (sent < count) begin
			if (run_left == 0) begin
				run_left = $urandom_range(2, 24);
				case ($urandom_range(3))
					0:       goal = sb.low_end;
					1:       goal = sb.high_end;
					default: goal = 8'($urandom);
				endcase
			end
			if ($urandom_range(99) < 25) begin
				present = 8'($urandom);
				wanted  = 8'($urandom);
			end else begin
				present = sb.last_duty;
				wanted  = goal;
				run_left--;
			end
			send_tick(present, wanted);
			sent++;
			// hold off until the pipeline is empty now and then
			if ($urandom_range(49) == 0)
				finish_phase();
		end
		finish_phase();
	endtask

	initial begin
		logic [7:0] lo;
		logic [7:0] hi;
		sb = new();
		set_idle(IDLE_NONE);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: full band, both directions, equal values, clipping
		send_tick(8'd0, 8'd255);
		send_tick(8'd255, 8'd0);
		send_tick(8'd0, 8'd0);
		send_tick(8'd255, 8'd255);
		send_tick(8'd100, 8'd100);
		send_tick(8'd0, 8'd1);
		send_tick(8'd200, 8'd0);
		finish_phase();

		// inverted band, zero ramp and tick times, weaker-direction ramp at its maximum
		program_regs(8'd200, 8'd50, 16'd0, 16'hFFFF, 16'd0);
		send_tick(8'd0, 8'd255);
		send_tick(8'd50, 8'd200);
		send_tick(8'd255, 8'd0);
		send_tick(8'd120, 8'd130);
		finish_phase();

		// empty band
		program_regs(8'd77, 8'd77, 16'hFFFF, 16'd1, 16'hFFFF);
		send_tick(8'd0, 8'd255);
		send_tick(8'd255, 8'd0);
		finish_phase();

		// extreme times on the full band
		program_regs(8'd0, 8'd255, 16'd1, 16'hFFFF, 16'hFFFF);
		send_tick(8'd0, 8'd255);
		send_tick(8'd255, 8'd0);
		send_tick(8'h55, 8'hAA);
		send_tick(8'hAA, 8'h55);
		finish_phase();

		// fully inverted band with short ramps
		program_regs(8'd255, 8'd0, 16'd3, 16'd7, 16'd2);
		send_tick(8'd0, 8'd255);
		send_tick(sb.last_duty, 8'd255);
		send_tick(sb.last_duty, 8'd0);
		send_tick(sb.last_duty, 8'd0);
		finish_phase();

		for (int p = 0; p < 10; p++) begin
			set_idle(idle_mode_t'(p % 4));
			lo = 8'($urandom);
			hi = 8'($urandom);
			case ($urandom_range(7))
				0: begin lo = 8'd0; hi = 8'd255; end
				1: begin lo = 8'd255; hi = 8'd0; end
				2: hi = lo;
				default: ;
			endcase
			program_regs(lo, hi, pick_seconds(), pick_seconds(), pick_seconds());
			run_random_phase(53);
		end

		set_idle(IDLE_NONE);
		wait_results();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (sb.failed())
			$display("FAIL");
		else
			$display("PASS");
		$finish;
	end

endmodule

`default_nettype wire
